>>> sv/color_printer_byte_stream_encoder_macros.svh
// Assertion macros used by the checker file of the printer encoder.
`ifndef COLOR_PRINTER_BYTE_STREAM_ENCODER_MACROS_SVH
`define COLOR_PRINTER_BYTE_STREAM_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPBSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPBSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cpbse_pkg.sv
package cpbse_pkg;

   // Command codes on the request channel.
   localparam logic [2:0] CMD_PIXEL  = 3'd0;
   localparam logic [2:0] CMD_EOL    = 3'd1;
   localparam logic [2:0] CMD_HEADER = 3'd2;
   localparam logic [2:0] CMD_FF     = 3'd3;
   localparam logic [2:0] CMD_CLOSE  = 3'd4;
   localparam logic [2:0] CMD_RESET  = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_DEPTH   = 3'd0;
   localparam logic [2:0] REG_RETRACE = 3'd1;
   localparam logic [2:0] REG_ORIENT  = 3'd2;
   localparam logic [2:0] REG_SIZING  = 3'd3;
   localparam logic [2:0] REG_INVERT  = 3'd4;
   localparam logic [2:0] REG_WIDTH   = 3'd5;
   localparam logic [2:0] REG_HEIGHT  = 3'd6;

   localparam int CSR_WIDTH = 14;

   // Color depth codes.
   localparam logic [1:0] DEPTH_ONE  = 2'd0;
   localparam logic [1:0] DEPTH_TWO  = 2'd1;
   localparam logic [1:0] DEPTH_FOUR = 2'd2;

   // Printer byte codes.
   localparam logic [7:0] DATA_BIT   = 8'h80;
   localparam logic [7:0] SYNC_BIT   = 8'h40;
   localparam logic [7:0] CODE_EOT   = 8'h01;
   localparam logic [7:0] CODE_EOL   = 8'h02;
   localparam logic [7:0] CODE_ABORT = 8'h03;
   localparam logic [7:0] CODE_COPY  = 8'h04;
   localparam logic [7:0] CODE_RSV   = 8'h05;

   localparam logic [13:0] DEF_WIDTH  = 14'd1536;
   localparam logic [13:0] DEF_HEIGHT = 14'd1152;

   // One unit of work for the back end: a header, or one or two literal bytes.
   typedef struct packed {
      logic       header;
      logic       two;
      logic [7:0] byte0;
      logic [7:0] byte1;
   } job_type;

   // Configuration as seen by the back end.
   typedef struct packed {
      logic [1:0]  depth;
      logic [2:0]  retrace;
      logic [1:0]  orient;
      logic        sizing;
      logic        invert;
      logic [13:0] width;
      logic [13:0] height;
   } cfg_type;

endpackage

>>> sv/cpbse_front.sv
module cpbse_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [2:0]           cmd,
   input  logic [3:0]           red,
   input  logic [3:0]           green,
   input  logic [3:0]           blue,
   input  logic [1:0]           depth,
   output logic                 job_valid,
   output cpbse_pkg::job_type   job
);
   import cpbse_pkg::*;

   logic       half_ff, half_in;
   logic [7:0] held_ff, held_in;
   logic       has_job;
   logic [2:0] one_bit;

   assign one_bit = {blue[0], green[0], red[0]};

   // Classify the command and build the job; track the held one-bit pixel.
   always_comb begin
      half_in   = half_ff;
      held_in   = held_ff;
      has_job   = 1'b0;
      job       = '0;
      unique case (cmd)
         CMD_PIXEL: begin
            if (depth == DEPTH_TWO) begin
               has_job   = 1'b1;
               job.byte0 = {2'b11, blue[1:0], green[1:0], red[1:0]};
            end else if (depth == DEPTH_FOUR) begin
               has_job   = 1'b1;
               job.two   = 1'b1;
               job.byte0 = {2'b11, blue[3:2], green[3:2], red[3:2]};
               job.byte1 = {2'b10, blue[1:0], green[1:0], red[1:0]};
            end else if (!half_ff) begin
               half_in = 1'b1;
               held_in = DATA_BIT | SYNC_BIT | {5'd0, one_bit};
            end else begin
               half_in   = 1'b0;
               has_job   = 1'b1;
               job.byte0 = {held_ff[7:6], one_bit, held_ff[2:0]};
            end
         end
         CMD_EOL: begin
            has_job = 1'b1;
            half_in = 1'b0;
            if (half_ff) begin
               job.two   = 1'b1;
               job.byte0 = held_ff;
               job.byte1 = CODE_EOL;
            end else begin
               job.byte0 = CODE_EOL;
            end
         end
         CMD_HEADER: begin
            has_job    = 1'b1;
            half_in    = 1'b0;
            job.header = 1'b1;
         end
         CMD_FF: begin
            has_job   = 1'b1;
            job.byte0 = CODE_EOT;
         end
         CMD_CLOSE: begin
            has_job   = 1'b1;
            half_in   = 1'b0;
            job.two   = 1'b1;
            job.byte0 = CODE_EOT;
            job.byte1 = CODE_ABORT;
         end
         CMD_RESET: begin
            has_job   = 1'b1;
            half_in   = 1'b0;
            job.byte0 = CODE_ABORT;
         end
         default: begin
         end
      endcase
   end

   assign job_valid = accept && has_job;

   // Pixel phase state changes only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 1'b0;
         held_ff <= '0;
      end else if (accept) begin
         half_ff <= half_in;
         held_ff <= held_in;
      end
   end

endmodule

>>> sv/cpbse_queue.sv
module cpbse_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  cpbse_pkg::job_type   wr_job,
   output logic                 full,
   output logic                 rd_valid,
   output cpbse_pkg::job_type   rd_job,
   input  logic                 rd_pop
);
   import cpbse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == CNT_FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_job   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_pop && rd_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

>>> sv/cpbse_back.sv
module cpbse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cpbse_pkg::cfg_type   cfg,
   input  logic                 job_valid,
   input  cpbse_pkg::job_type   job,
   output logic                 job_pop,
   output logic                 out_valid,
   output logic [7:0]           out_byte,
   output logic                 out_last,
   input  logic                 out_pop
);
   import cpbse_pkg::*;

   // Header byte positions.
   localparam logic [3:0] HDR_RSV     = 4'd0;
   localparam logic [3:0] HDR_COPY    = 4'd1;
   localparam logic [3:0] HDR_MODE    = 4'd2;
   localparam logic [3:0] HDR_RETRACE = 4'd3;
   localparam logic [3:0] HDR_W_HI    = 4'd4;
   localparam logic [3:0] HDR_W_LO    = 4'd5;
   localparam logic [3:0] HDR_H_HI    = 4'd6;
   localparam logic [3:0] HDR_H_LO    = 4'd7;
   localparam logic [3:0] HDR_SUM     = 4'd8;
   localparam logic [3:0] HDR_EOL     = 4'd9;

   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        emit, is_last;
   logic [6:0]  mode;
   logic [13:0] w_eff, h_eff;
   logic [6:0]  checksum;
   logic [7:0]  hdr_byte, cur_byte;

   // Copy request fields.
   assign mode  = {1'b0, cfg.depth == DEPTH_FOUR, cfg.depth == DEPTH_TWO, cfg.orient,
                   !cfg.sizing, cfg.invert};
   assign w_eff = (cfg.width == '0) ? DEF_WIDTH : cfg.width;
   assign h_eff = (cfg.height == '0) ? DEF_HEIGHT : cfg.height;
   // Bit 7 of every summed byte drops out of a 7-bit checksum.
   assign checksum = CODE_COPY[6:0] + mode + {4'd0, cfg.retrace} + w_eff[13:7] + w_eff[6:0]
                     + h_eff[13:7] + h_eff[6:0];

   always_comb begin
      unique case (idx_ff)
         HDR_RSV:     hdr_byte = CODE_RSV;
         HDR_COPY:    hdr_byte = CODE_COPY;
         HDR_MODE:    hdr_byte = {1'b1, mode};
         HDR_RETRACE: hdr_byte = {5'b10000, cfg.retrace};
         HDR_W_HI:    hdr_byte = {1'b1, w_eff[13:7]};
         HDR_W_LO:    hdr_byte = {1'b1, w_eff[6:0]};
         HDR_H_HI:    hdr_byte = {1'b1, h_eff[13:7]};
         HDR_H_LO:    hdr_byte = {1'b1, h_eff[6:0]};
         HDR_SUM:     hdr_byte = {1'b1, checksum};
         HDR_EOL:     hdr_byte = CODE_EOL;
         default:     hdr_byte = CODE_EOL;
      endcase
   end

   // Pick the byte of the head job and decide whether it ends the job.
   always_comb begin
      if (job.header) begin
         cur_byte = hdr_byte;
         is_last  = (idx_ff == HDR_EOL);
      end else begin
         cur_byte = (idx_ff == '0) ? job.byte0 : job.byte1;
         is_last  = !job.two || (idx_ff != '0);
      end
   end

   // One byte a cycle while the output register is free or being drained.
   assign emit    = job_valid && (!valid_ff || out_pop);
   assign job_pop = emit && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_pop;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (emit) begin
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

>>> sv/color_printer_byte_stream_encoder.sv
// Color printer byte stream encoder.
// Requests (req_cmd with req_red, req_green, req_blue) enter through a queue-like
// port: a request is taken on a clock edge with req_push high and req_full low.
// Printer bytes leave through a second queue-like port: while rsp_empty is low,
// rsp_out_byte and rsp_last_byte show the oldest byte, and rsp_pop takes it.
// rsp_last_byte marks the final byte caused by one request.
// Configuration is written through csr_write_enable, csr_index and csr_wdata;
// the user must write it only while no request is in flight, since the block
// itself does not enforce this. The back end sends one byte per cycle while
// the output register is free or rsp_pop drains it; a request makes one or two
// bytes for pixels and defined codes, ten for a header. Requests keep being
// taken while the job queue between front and back has room. A one-bit pixel
// that opens a pair makes no byte. A stalled rsp_pop holds the output byte;
// the queue fills and then req_full rises. Reset empties the queue and the
// output register, drops a held pixel, and loads the default configuration.
module color_printer_byte_stream_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [2:0]                        req_cmd,
   input  logic [3:0]                        req_red,
   input  logic [3:0]                        req_green,
   input  logic [3:0]                        req_blue,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_byte,
   input  logic                              csr_write_enable,
   input  logic [2:0]                        csr_index,
   input  logic [cpbse_pkg::CSR_WIDTH-1:0]   csr_wdata
);
   import cpbse_pkg::*;

   cfg_type cfg_ff;
   logic    accept;
   logic    front_valid;
   job_type front_job;
   logic    head_valid;
   job_type head_job;
   logic    head_pop;
   logic    out_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth   <= DEPTH_ONE;
         cfg_ff.retrace <= 3'd1;
         cfg_ff.orient  <= '0;
         cfg_ff.sizing  <= 1'b0;
         cfg_ff.invert  <= 1'b0;
         cfg_ff.width   <= '0;
         cfg_ff.height  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_DEPTH:   cfg_ff.depth   <= csr_wdata[1:0];
            REG_RETRACE: cfg_ff.retrace <= csr_wdata[2:0];
            REG_ORIENT:  cfg_ff.orient  <= csr_wdata[1:0];
            REG_SIZING:  cfg_ff.sizing  <= csr_wdata[0];
            REG_INVERT:  cfg_ff.invert  <= csr_wdata[0];
            REG_WIDTH:   cfg_ff.width   <= csr_wdata[13:0];
            REG_HEIGHT:  cfg_ff.height  <= csr_wdata[13:0];
            default: begin
            end
         endcase
      end
   end

   assign accept = req_push && !req_full;

   // Front end: classify the request and keep the pixel phase.
   cpbse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_cmd),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .depth     (cfg_ff.depth),
      .job_valid (front_valid),
      .job       (front_job)
   );

   // Job queue between the two halves.
   cpbse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_job   (front_job),
      .full     (req_full),
      .rd_valid (head_valid),
      .rd_job   (head_job),
      .rd_pop   (head_pop)
   );

   // Back end: serialize each job into printer bytes.
   cpbse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (head_pop),
      .out_valid (out_valid),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_last_byte),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty = !out_valid;

endmodule

>>> sv/cpbse_checker.sv
`include "color_printer_byte_stream_encoder_macros.svh"

module cpbse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);
   import cpbse_pkg::*;

   logic       stall;
   logic [8:0] shown;
   logic       ctl_byte;
   logic       end_code;
   logic       mid_code;

   // The byte on the port, whether it waits, and which control codes it may be.
   assign stall    = !rsp_empty && !rsp_pop;
   assign shown    = {rsp_out_byte, rsp_last_byte};
   assign ctl_byte = !rsp_empty && !rsp_out_byte[7];
   assign end_code = (rsp_out_byte == CODE_EOL) || (rsp_out_byte == CODE_EOT)
                     || (rsp_out_byte == CODE_ABORT);
   assign mid_code = (rsp_out_byte == CODE_RSV) || (rsp_out_byte == CODE_COPY)
                     || (rsp_out_byte == CODE_EOT);

   // Reset leaves nothing to deliver and room for a request.
   `CPBSE_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !req_full, "busy after reset")

   // A byte that is not taken stays on the port unchanged.
   `CPBSE_ASSERT_NEXT(a_hold, clock, reset, stall, !rsp_empty && $stable(shown), "held byte changed")

   // A final control byte is end of line, end of transmission or abort.
   `CPBSE_ASSERT_NOW(a_last_code, clock, reset, ctl_byte && rsp_last_byte, end_code, "bad final code")

   // A control byte in the middle of a request is reserve, copy or end of transmission.
   `CPBSE_ASSERT_NOW(a_mid_code, clock, reset, ctl_byte && !rsp_last_byte, mid_code, "bad inner code")

endmodule

bind color_printer_byte_stream_encoder cpbse_checker u_checker (.*);

>>> sim/color_printer_byte_stream_encoder_test.sv
module color_printer_byte_stream_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cpbse_pkg::*;

   // Codes the block must take and ignore, and the depth code with no meaning.
   localparam logic [2:0] CMD_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;
   localparam logic [1:0] DEPTH_SPARE    = 2'd3;

   // Mode byte bits of the copy request.
   localparam logic [7:0] MODE_INVERT    = 8'h01;
   localparam logic [7:0] MODE_NO_SIZING = 8'h02;
   localparam logic [7:0] MODE_TWO_BIT   = 8'h10;
   localparam logic [7:0] MODE_FOUR_BIT  = 8'h20;

   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 150;
   localparam int QUIET_LIMIT    = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 42;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } printer_byte_t;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [2:0]           req_cmd;
   logic [3:0]           req_red;
   logic [3:0]           req_green;
   logic [3:0]           req_blue;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_last_byte;
   logic                 csr_write_enable;
   logic [2:0]           csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;

   // Predictor state: configuration copy and the held one-bit pixel.
   cfg_type       printer_cfg;
   logic          half_pending;
   logic [7:0]    held_byte;
   printer_byte_t expected_bytes [$];

   bit sender_idling;
   bit receiver_idling;
   bit hold_pending;
   int error_count;
   int requests_sent;
   int bytes_checked;
   int settings_loaded;
   int full_cycles;
   int quiet_cycles;

   color_printer_byte_stream_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Packs two bits of each color as blue, green, red from the top down.
   function automatic logic [7:0] pack_pairs(input logic [1:0] r, g, b);
      return {2'b00, b, g, r};
   endfunction

   // Works out the printer bytes that one accepted request causes.
   task automatic encode_request(input logic [2:0] cmd, input logic [3:0] r, g, b);
      logic [7:0]  staged [$];
      logic [7:0]  copy_req [7];
      logic [7:0]  mode;
      logic [7:0]  sum;
      logic [2:0]  pair_bits;
      logic [13:0] w;
      logic [13:0] h;
      case (cmd)
         CMD_PIXEL: begin
            if (printer_cfg.depth == DEPTH_TWO) begin
               staged.push_back(DATA_BIT | SYNC_BIT | pack_pairs(r[1:0], g[1:0], b[1:0]));
            end else if (printer_cfg.depth == DEPTH_FOUR) begin
               staged.push_back(DATA_BIT | SYNC_BIT | pack_pairs(r[3:2], g[3:2], b[3:2]));
               staged.push_back(DATA_BIT | pack_pairs(r[1:0], g[1:0], b[1:0]));
            end else begin
               // One bit per color: the first pixel of a pair is only held.
               pair_bits = {b[0], g[0], r[0]};
               if (!half_pending) begin
                  half_pending = 1'b1;
                  held_byte = DATA_BIT | SYNC_BIT | {5'b00000, pair_bits};
               end else begin
                  half_pending = 1'b0;
                  staged.push_back(held_byte | {2'b00, pair_bits, 3'b000});
               end
            end
         end
         CMD_EOL: begin
            if (half_pending) begin
               staged.push_back(held_byte);
            end
            staged.push_back(CODE_EOL);
            half_pending = 1'b0;
         end
         CMD_HEADER: begin
            half_pending = 1'b0;
            mode = printer_cfg.sizing ? 8'h00 : MODE_NO_SIZING;
            if (printer_cfg.invert) begin
               mode |= MODE_INVERT;
            end
            mode |= {4'b0000, printer_cfg.orient, 2'b00};
            if (printer_cfg.depth == DEPTH_TWO) begin
               mode |= MODE_TWO_BIT;
            end else if (printer_cfg.depth == DEPTH_FOUR) begin
               mode |= MODE_FOUR_BIT;
            end
            w = (printer_cfg.width == 0) ? DEF_WIDTH : printer_cfg.width;
            h = (printer_cfg.height == 0) ? DEF_HEIGHT : printer_cfg.height;
            copy_req[0] = DATA_BIT | mode;
            copy_req[1] = DATA_BIT | {5'b00000, printer_cfg.retrace};
            copy_req[2] = DATA_BIT | {1'b0, w[13:7]};
            copy_req[3] = DATA_BIT | {1'b0, w[6:0]};
            copy_req[4] = DATA_BIT | {1'b0, h[13:7]};
            copy_req[5] = DATA_BIT | {1'b0, h[6:0]};
            // The checksum starts from the copy code and keeps seven bits.
            sum = CODE_COPY;
            for (int i = 0; i < 6; i++) begin
               sum += copy_req[i];
            end
            copy_req[6] = DATA_BIT | {1'b0, sum[6:0]};
            staged.push_back(CODE_RSV);
            staged.push_back(CODE_COPY);
            for (int i = 0; i < 7; i++) begin
               staged.push_back(copy_req[i]);
            end
            staged.push_back(CODE_EOL);
         end
         CMD_FF: begin
            staged.push_back(CODE_EOT);
         end
         CMD_CLOSE: begin
            staged.push_back(CODE_EOT);
            staged.push_back(CODE_ABORT);
            half_pending = 1'b0;
         end
         CMD_RESET: begin
            staged.push_back(CODE_ABORT);
            half_pending = 1'b0;
         end
         default: begin
         end
      endcase
      foreach (staged[i]) begin
         expected_bytes.push_back(printer_byte_t'{staged[i], i == staged.size() - 1});
      end
   endtask

   // Offers one request, waits for it to be taken and records its bytes.
   task automatic send_request(input logic [2:0] cmd, input logic [3:0] r, g, b);
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_push  <= 1'b1;
      req_cmd   <= cmd;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (req_full);
      encode_request(cmd, r, g, b);
      if (cmd <= CMD_RESET) begin
         requests_sent++;
      end
   endtask

   task automatic send_pixel(input logic [3:0] r, g, b);
      send_request(CMD_PIXEL, r, g, b);
   endtask

   task automatic send_code(input logic [2:0] cmd);
      send_request(cmd, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)));
   endtask

   // Stops offering requests and lets every expected byte come out.
   task automatic wait_until_idle();
      req_push <= 1'b0;
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all seven registers while the block is idle.
   task automatic load_settings(input cfg_type s);
      logic [2:0] reg_order [7] = '{REG_DEPTH, REG_RETRACE, REG_ORIENT, REG_SIZING,
                                    REG_INVERT, REG_WIDTH, REG_HEIGHT};
      wait_until_idle();
      foreach (reg_order[k]) begin
         csr_write_enable <= 1'b1;
         csr_index        <= reg_order[k];
         case (reg_order[k])
            REG_DEPTH:   csr_wdata <= CSR_WIDTH'(s.depth);
            REG_RETRACE: csr_wdata <= CSR_WIDTH'(s.retrace);
            REG_ORIENT:  csr_wdata <= CSR_WIDTH'(s.orient);
            REG_SIZING:  csr_wdata <= CSR_WIDTH'(s.sizing);
            REG_INVERT:  csr_wdata <= CSR_WIDTH'(s.invert);
            REG_WIDTH:   csr_wdata <= s.width;
            default:     csr_wdata <= s.height;
         endcase
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      printer_cfg = s;
      settings_loaded++;
   endtask

   task automatic load_depth(input logic [1:0] depth);
      cfg_type s;
      s = printer_cfg;
      s.depth = depth;
      load_settings(s);
   endtask

   // Picks a setting, with the ends of each range coming up often.
   function automatic cfg_type random_settings();
      cfg_type s;
      s.depth   = 2'($urandom_range(0, 3));
      s.retrace = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 1) * 7)
                                              : 3'($urandom_range(1, 7));
      s.orient  = 2'($urandom_range(0, 3));
      s.sizing  = 1'($urandom_range(0, 1));
      s.invert  = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0:       s.width = '0;
         1:       s.width = '1;
         default: s.width = 14'($urandom_range(0, 16383));
      endcase
      case ($urandom_range(0, 3))
         0:       s.height = '0;
         1:       s.height = '1;
         default: s.height = 14'($urandom_range(0, 16383));
      endcase
      return s;
   endfunction

   // The header with the settings that reset leaves, default sizes included.
   task automatic test_header_defaults();
      send_code(CMD_HEADER);
      wait_until_idle();
   endtask

   // Pixel pairs at one bit, and every way a held pixel is flushed or dropped.
   task automatic test_one_bit_packing();
      load_depth(DEPTH_ONE);
      send_pixel(4'h0, 4'h0, 4'h0);
      send_pixel(4'hF, 4'hF, 4'hF);
      send_pixel(4'hF, 4'hF, 4'hF);
      send_code(CMD_EOL);
      send_code(CMD_EOL);
      send_pixel(4'h5, 4'hA, 4'h5);
      send_code(CMD_HEADER);
      send_pixel(4'hE, 4'h1, 4'hF);
      send_code(CMD_CLOSE);
      send_pixel(4'h1, 4'h1, 4'h1);
      send_code(CMD_RESET);
      wait_until_idle();
   endtask

   // Two and four bit pixels, form feed and the codes that do nothing.
   task automatic test_wide_pixels_and_codes();
      load_depth(DEPTH_TWO);
      send_pixel(4'hF, 4'hF, 4'hF);
      send_pixel(4'h0, 4'h0, 4'h0);
      load_depth(DEPTH_FOUR);
      send_pixel(4'hF, 4'hF, 4'hF);
      send_pixel(4'hA, 4'h5, 4'hC);
      send_code(CMD_FF);
      send_code(CMD_SPARE_LOW);
      send_code(CMD_SPARE_HIGH);
      wait_until_idle();
   endtask

   // Headers with every field at its top, then at its bottom with the spare depth.
   task automatic test_header_extremes();
      cfg_type s;
      s = '{depth: DEPTH_FOUR, retrace: 3'd7, orient: 2'd3, sizing: 1'b1, invert: 1'b1,
            width: '1, height: '1};
      load_settings(s);
      send_code(CMD_HEADER);
      s = '{depth: DEPTH_SPARE, retrace: 3'd0, orient: 2'd0, sizing: 1'b0, invert: 1'b0,
            width: 14'd1, height: 14'd1};
      load_settings(s);
      send_code(CMD_HEADER);
      wait_until_idle();
   endtask

   // A held pixel survives a change of depth and pairs with a later one.
   task automatic test_depth_change_mid_line();
      load_depth(DEPTH_ONE);
      send_pixel(4'hF, 4'hF, 4'hF);
      load_depth(DEPTH_TWO);
      send_pixel(4'h3, 4'h3, 4'h3);
      load_depth(DEPTH_SPARE);
      send_pixel(4'h0, 4'hF, 4'h0);
      wait_until_idle();
   endtask

   // Mostly whole lines of pixels after a header, with some loose codes and noise.
   task automatic run_random_phase(input bit squeeze);
      cfg_type s;
      int      start;
      int      choice;
      start = requests_sent;
      s = random_settings();
      if (squeeze) begin
         s.depth = DEPTH_FOUR;
      end
      load_settings(s);
      send_code(CMD_HEADER);
      if (squeeze) begin
         hold_pending = 1'b1;
      end
      while (requests_sent - start < PHASE_REQUESTS) begin
         choice = $urandom_range(0, 19);
         if (choice < 15) begin
            repeat ($urandom_range(0, 9)) begin
               send_pixel(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)));
            end
            send_code(CMD_EOL);
         end else if (choice == 15) begin
            send_code(CMD_FF);
         end else if (choice == 16) begin
            send_code(CMD_CLOSE);
         end else if (choice == 17) begin
            send_code(CMD_RESET);
         end else if (choice == 18) begin
            send_code(CMD_HEADER);
         end else begin
            send_code(3'($urandom_range(0, 7)));
         end
      end
      wait_until_idle();
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // One phase in the middle and the last two run without idling.
         sender_idling   = (p < RANDOM_PHASES - 2) && (p != 3);
         receiver_idling = (p < RANDOM_PHASES - 2) && (p != 3);
         run_random_phase(p == 2);
      end
   endtask

   // Result side: pops with random stalls, and one long hold-off on request.
   initial begin
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
      end
   end

   // Each byte taken is compared with the oldest expected one.
   always @(posedge clock) begin : byte_check
      printer_byte_t want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte: expected nothing, got %h", rsp_out_byte);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_last_byte !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, rsp_last_byte);
               error_count++;
            end
            bytes_checked++;
         end
      end
   end

   // Ends the run when neither side has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && req_push && req_full) begin
         full_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("No request or byte moved for %0d cycles.", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_cmd          <= CMD_PIXEL;
      req_red          <= '0;
      req_green        <= '0;
      req_blue         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_DEPTH;
      csr_wdata        <= '0;
      printer_cfg      = '{depth: DEPTH_ONE, retrace: 3'd1, orient: 2'd0, sizing: 1'b0,
                           invert: 1'b0, width: '0, height: '0};
      half_pending     = 1'b0;
      held_byte        = '0;
      sender_idling    = 1'b1;
      receiver_idling  = 1'b1;
      hold_pending     = 1'b0;
      error_count      = 0;
      requests_sent    = 0;
      bytes_checked    = 0;
      settings_loaded  = 0;
      full_cycles      = 0;
      quiet_cycles     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_header_defaults();
      test_one_bit_packing();
      test_wide_pixels_and_codes();
      test_header_extremes();
      test_depth_change_mid_line();
      test_random_traffic();
      wait_until_idle();

      $display("Sent %0d requests under %0d register settings; checked %0d printer bytes.",
               requests_sent, settings_loaded, bytes_checked);
      $display("The request side was held back by a full queue for %0d cycles.",
               full_cycles);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
